// ===== hdl/rtb_pkg.sv =====
// Package for the rectangle transform bounds block: formats, widths and shared types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package rtb_pkg;
    localparam int COORD_FRAC_BITS = 16;
    localparam int PERSP_FRAC_BITS = 28;
    localparam int NW = 66 - COORD_FRAC_BITS;
    localparam int WW = 66 - PERSP_FRAC_BITS;
    localparam int CW = WW + 32 - COORD_FRAC_BITS;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STG = 32 / DIV_STEPS;
    localparam int NSTG = DIV_STG + 5;
    localparam int AW = 6;

    localparam logic [2:0] REG_SCALE = 3'd0;
    localparam logic [2:0] REG_SKEW = 3'd1;
    localparam logic [2:0] REG_TRANSLATE = 3'd2;
    localparam logic [2:0] REG_PERSP = 3'd3;
    localparam logic [2:0] REG_BIAS = 3'd4;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] kx;
        logic signed [31:0] ky;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] pb;
    } t_mat;

    typedef struct packed {
        logic [WW-1:0] rem;
        logic [31:0]   lo;
        logic [31:0]   q;
        logic [WW-1:0] ud;
        logic          neg;
        logic          ovf;
        logic          zero;
    } t_div;
endpackage
`default_nettype wire

// ===== hdl/rtb_cfg.sv =====
// Configuration register file with APB-style access and the axis-aligned flag.
// Depends on rtb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtb_cfg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [rtb_pkg::AW-1:0] paddr,
    input  wire logic [63:0]           pwdata,
    output logic      [63:0]           prdata,
    output logic                       pready,
    output rtb_pkg::t_mat              o_mat,
    output logic                       o_aligned
);
    import rtb_pkg::*;

    logic [63:0] r_scale, r_skew, r_trans, r_persp;
    logic [31:0] r_bias;
    logic        r_aligned, n_aligned;
    logic [2:0]  w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[AW-1:3];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= {32'(1 << COORD_FRAC_BITS), 32'(1 << COORD_FRAC_BITS)};
            r_skew    <= '0;
            r_trans   <= '0;
            r_persp   <= '0;
            r_bias    <= 32'(1 << COORD_FRAC_BITS);
            r_aligned <= 1'b1;
        end else begin
            r_aligned <= n_aligned;
            if (w_wr) begin
                case (w_idx)
                    REG_SCALE:     r_scale <= pwdata;
                    REG_SKEW:      r_skew  <= pwdata;
                    REG_TRANSLATE: r_trans <= pwdata;
                    REG_PERSP:     r_persp <= pwdata;
                    REG_BIAS:      r_bias  <= pwdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (w_idx)
            REG_SCALE:     prdata = r_scale;
            REG_SKEW:      prdata = r_skew;
            REG_TRANSLATE: prdata = r_trans;
            REG_PERSP:     prdata = r_persp;
            REG_BIAS:      prdata = {32'd0, r_bias};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_mat.sx = r_scale[63:32];
        o_mat.sy = r_scale[31:0];
        o_mat.kx = r_skew[63:32];
        o_mat.ky = r_skew[31:0];
        o_mat.tx = r_trans[63:32];
        o_mat.ty = r_trans[31:0];
        o_mat.p0 = r_persp[63:32];
        o_mat.p1 = r_persp[31:0];
        o_mat.pb = r_bias;
    end

    always_comb begin
        if (r_persp != 64'd0 || r_bias != 32'(1 << COORD_FRAC_BITS)) begin
            n_aligned = 1'b0;
        end else if (r_skew != 64'd0) begin
            n_aligned = (r_scale == 64'd0) && (r_skew[63:32] != 32'd0)
                && (r_skew[31:0] != 32'd0);
        end else begin
            n_aligned = (r_scale[63:32] != 32'd0) && (r_scale[31:0] != 32'd0);
        end
    end

    assign o_aligned = r_aligned;
endmodule
`default_nettype wire

// ===== hdl/rtb_div.sv =====
// One registered stage of the restoring divider, retiring several quotient bits.
// Depends on rtb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtb_div (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire rtb_pkg::t_div i_d,
    output rtb_pkg::t_div      o_d
);
    import rtb_pkg::*;

    t_div          r_d, n_d;
    logic [WW:0]   w_trial;

    always_comb begin
        n_d = i_d;
        w_trial = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_trial = {n_d.rem, n_d.lo[31]};
            n_d.lo  = {n_d.lo[30:0], 1'b0};
            if (w_trial >= {1'b0, n_d.ud}) begin
                n_d.rem = WW'(w_trial - {1'b0, n_d.ud});
                n_d.q   = {n_d.q[30:0], 1'b1};
            end else begin
                n_d.rem = w_trial[WW-1:0];
                n_d.q   = {n_d.q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// ===== hdl/rtb_corner.sv =====
// Maps one corner through the matrix: products, sums, divider set-up, divider and clamp.
// Depends on rtb_pkg and rtb_div.
`timescale 1ns / 1ps
`default_nettype none
module rtb_corner (
    input  wire logic                    i_clk,
    input  wire logic [rtb_pkg::NSTG-2:0] i_en,
    input  wire rtb_pkg::t_mat           i_mat,
    input  wire logic signed [31:0]      i_x,
    input  wire logic signed [31:0]      i_y,
    output logic signed [31:0]           o_x,
    output logic signed [31:0]           o_y,
    output logic                         o_sat
);
    import rtb_pkg::*;

    logic signed [63:0] r_ax, r_bx, r_ay, r_by, r_aw, r_bw;
    logic signed [NW-1:0] r_nx, r_ny;
    logic signed [WW-1:0] r_w;
    logic [NW-1:0] w_ux, w_uy;
    logic [WW-1:0] w_ud;
    t_div w_dx, w_dy;
    t_div r_dx0, r_dy0;
    t_div w_cx [0:DIV_STG];
    t_div w_cy [0:DIV_STG];
    logic signed [31:0] r_x, r_y, n_x, n_y;
    logic r_sat, n_sat, w_sx, w_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ax <= i_x * i_mat.sx;
            r_bx <= i_y * i_mat.kx;
            r_ay <= i_x * i_mat.ky;
            r_by <= i_y * i_mat.sy;
            r_aw <= i_x * i_mat.p0;
            r_bw <= i_y * i_mat.p1;
        end
        if (i_en[1]) begin
            r_nx <= NW'(r_ax >>> COORD_FRAC_BITS) + NW'(r_bx >>> COORD_FRAC_BITS)
                + NW'(i_mat.tx);
            r_ny <= NW'(r_ay >>> COORD_FRAC_BITS) + NW'(r_by >>> COORD_FRAC_BITS)
                + NW'(i_mat.ty);
            r_w  <= WW'(r_aw >>> PERSP_FRAC_BITS) + WW'(r_bw >>> PERSP_FRAC_BITS)
                + WW'(i_mat.pb);
        end
    end

    always_comb begin
        w_ux = r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
        w_uy = r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
        w_ud = r_w[WW-1] ? WW'(-r_w) : WW'(r_w);
        w_dx.ud   = w_ud;
        w_dx.zero = (r_w == '0);
        w_dx.neg  = r_nx[NW-1] ^ r_w[WW-1];
        w_dx.ovf  = CW'(w_ux) >= (CW'(w_ud) << (32 - COORD_FRAC_BITS));
        w_dx.rem  = WW'(w_ux >> (32 - COORD_FRAC_BITS));
        w_dx.lo   = {w_ux[31-COORD_FRAC_BITS:0], {COORD_FRAC_BITS{1'b0}}};
        w_dx.q    = '0;
        w_dy.ud   = w_ud;
        w_dy.zero = (r_w == '0);
        w_dy.neg  = r_ny[NW-1] ^ r_w[WW-1];
        w_dy.ovf  = CW'(w_uy) >= (CW'(w_ud) << (32 - COORD_FRAC_BITS));
        w_dy.rem  = WW'(w_uy >> (32 - COORD_FRAC_BITS));
        w_dy.lo   = {w_uy[31-COORD_FRAC_BITS:0], {COORD_FRAC_BITS{1'b0}}};
        w_dy.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_dx0 <= w_dx;
            r_dy0 <= w_dy;
        end
    end

    assign w_cx[0] = r_dx0;
    assign w_cy[0] = r_dy0;

    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        rtb_div u_dx (.i_clk(i_clk), .i_en(i_en[3+g]), .i_d(w_cx[g]), .o_d(w_cx[g+1]));
        rtb_div u_dy (.i_clk(i_clk), .i_en(i_en[3+g]), .i_d(w_cy[g]), .o_d(w_cy[g+1]));
    end

    function automatic logic [32:0] clamp(input t_div d);
        logic [32:0] mag;
        logic [31:0] v;
        logic        s;
        mag = d.ovf ? {1'b1, 32'd0} : {1'b0, d.q};
        s = 1'b0;
        if (d.zero) begin
            v = '0;
        end else if (d.neg) begin
            if (mag > 33'h0_8000_0000) begin
                v = 32'h8000_0000;
                s = 1'b1;
            end else begin
                v = 32'(-mag);
            end
        end else if (mag > 33'h0_7FFF_FFFF) begin
            v = 32'h7FFF_FFFF;
            s = 1'b1;
        end else begin
            v = mag[31:0];
        end
        return {s, v};
    endfunction

    always_comb begin
        {w_sx, n_x} = clamp(w_cx[DIV_STG]);
        {w_sy, n_y} = clamp(w_cy[DIV_STG]);
        n_sat = w_sx | w_sy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3+DIV_STG]) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_sat <= n_sat;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_sat = r_sat;
endmodule
`default_nettype wire

// ===== hdl/rect_transform_bounds.sv =====
// Top level of the rectangle transform bounds block: handshake, corners and min/max stage.
// Depends on rtb_pkg, rtb_cfg and rtb_corner.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one rectangle request per cycle while the output is not stalled and returns
// its projected bounding box through registered stages; the 32-bit quotient of the perspective
// divide is retired four bits per stage over eight stages after the multiply, sum and set-up
// stages, followed by the clamp and min/max stages. When the output is stalled the pipeline
// fills up its empty stages before refusing requests.
module rect_transform_bounds (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [127:0]           s_tdata,  // rect_left, rect_top, rect_right, rect_bottom
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [127:0]                m_tdata,  // bound_left, bound_top, bound_right, bound_bottom
    output logic [1:0]                  m_tuser,  // stays_axis_aligned, saturated
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [rtb_pkg::AW-1:0] paddr,
    input  wire logic [63:0]            pwdata,
    output logic      [63:0]            prdata,
    output logic                        pready
);
    import rtb_pkg::*;

    t_mat w_mat;
    logic w_aligned;
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_rdy;
    logic signed [31:0] w_cx [0:3];
    logic signed [31:0] w_cy [0:3];
    logic [3:0] w_sat;
    logic signed [31:0] w_xl, w_xh, w_yl, w_yh;
    logic signed [31:0] r_xl, r_xh, r_yl, r_yh;
    logic r_al, r_sat;

    rtb_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_mat(w_mat), .o_aligned(w_aligned)
    );

    assign w_rdy[NSTG] = m_tready;
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] | w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? s_tvalid : r_v[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_corner
        rtb_corner u_corner (
            .i_clk(i_clk), .i_en(w_rdy[NSTG-2:0]), .i_mat(w_mat),
            .i_x((c == 0 || c == 3) ? s_tdata[31:0] : s_tdata[95:64]),
            .i_y((c == 0 || c == 1) ? s_tdata[63:32] : s_tdata[127:96]),
            .o_x(w_cx[c]), .o_y(w_cy[c]), .o_sat(w_sat[c])
        );
    end

    always_comb begin
        w_xl = w_cx[0];
        w_xh = w_cx[0];
        w_yl = w_cy[0];
        w_yh = w_cy[0];
        for (int c = 1; c < 4; c++) begin
            if (w_cx[c] < w_xl) w_xl = w_cx[c];
            if (w_cx[c] > w_xh) w_xh = w_cx[c];
            if (w_cy[c] < w_yl) w_yl = w_cy[c];
            if (w_cy[c] > w_yh) w_yh = w_cy[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG-1]) begin
            r_xl  <= w_xl;
            r_xh  <= w_xh;
            r_yl  <= w_yl;
            r_yh  <= w_yh;
            r_sat <= |w_sat;
            r_al  <= w_aligned;
        end
    end

    assign s_tready = w_rdy[0];
    assign m_tvalid = r_v[NSTG-1];
    assign m_tdata  = {r_yh, r_xh, r_yl, r_xl};
    assign m_tuser  = {r_sat, r_al};

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_xl <= r_xh) && (r_yl <= r_yh))
        else $error("bounding box minimum exceeds maximum");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> &r_v)
        else $error("request refused while a pipeline stage is empty");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid straight after reset");
endmodule
`default_nettype wire
